// ===== rtl/core/iftfg_pkg.sv =====
// Shared types and constants for the IPv4 transmit fragment header generator.
package iftfg_pkg;

    localparam int MAX_FRAGS  = 45;
    localparam int FRAG_CNT_W = $clog2(MAX_FRAGS);

    localparam logic [15:0] VER_IHL_TOS = 16'h4500;
    localparam logic [7:0]  TTL_VALUE   = 8'd64;
    localparam logic [10:0] HDR_BYTES   = 11'd20;

    // Input beat: payload_len, dest_addr, proto_num from bit 0 up.
    localparam int IN_W  = 56;
    // Output beat: total_length, ident, flags_offset, hdr_sum, slice_start, slice_len.
    localparam int OUT_W = 88;

    typedef struct packed {
        logic load;   // latch a new request
        logic step;   // emit current fragment and advance
    } iftfg_cmd_t;

    typedef struct packed {
        logic out_valid;   // output register holds an untaken beat
        logic frag_last;   // current fragment is the final one
    } iftfg_stat_t;

endpackage

// ===== rtl/core/iftfg_ctrl.sv =====
// Controller: sequences request intake and per-fragment emission.
module iftfg_ctrl
    import iftfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        m_tready,
    input  iftfg_stat_t stat,
    output iftfg_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;
    logic room;

    // output register free now or freed this cycle
    assign room = !stat.out_valid || m_tready;

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (room)
                begin
                    cmd.step = 1'b1;
                    if (stat.frag_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/core/iftfg_dp.sv =====
// Datapath: request registers, fragment walk, checksum and output register.
module iftfg_dp
    import iftfg_pkg::*;
#(
    parameter int FRAG_PAYLOAD = 1480
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast,
    input  iftfg_cmd_t        cmd,
    output iftfg_stat_t       stat
);

    localparam logic [15:0] FRAG_W = 16'(FRAG_PAYLOAD);
    localparam logic [FRAG_CNT_W-1:0] K_LAST = FRAG_CNT_W'(MAX_FRAGS - 1);

    logic [31:0]           local_ip_reg;
    logic [15:0]           next_ident_reg;

    logic [15:0]           rem_reg;
    logic [15:0]           start_reg;
    logic [FRAG_CNT_W-1:0] k_reg;
    logic [15:0]           ident_reg;
    logic [18:0]           base_sum_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_W-1:0]      out_data_reg;
    logic                  out_last_reg;

    logic [15:0]           in_len;
    logic [31:0]           in_dst;
    logic [7:0]            in_proto;
    logic [18:0]           base_sum;

    logic                  fits;
    logic                  frag_last;
    logic [10:0]           slen;
    logic [10:0]           tot;
    logic [13:0]           fo;
    logic [19:0]           sum_raw;
    logic [16:0]           sum_f1;
    logic [15:0]           sum_f2;
    logic [15:0]           hdr_sum;

    assign in_len   = s_tdata[15:0];
    assign in_dst   = s_tdata[47:16];
    assign in_proto = s_tdata[55:48];

    // header words that stay fixed across all fragments of one packet
    assign base_sum = 19'(VER_IHL_TOS) + 19'({TTL_VALUE, in_proto}) + 19'(next_ident_reg)
                    + 19'(local_ip_reg[31:16]) + 19'(local_ip_reg[15:0])
                    + 19'(in_dst[31:16]) + 19'(in_dst[15:0]);

    assign fits      = (rem_reg <= FRAG_W);
    assign frag_last = fits || (k_reg == K_LAST);
    assign slen      = fits ? rem_reg[10:0] : FRAG_W[10:0];
    assign tot       = slen + HDR_BYTES;
    assign fo        = {~frag_last, start_reg[15:3]};

    assign sum_raw = 20'(base_sum_reg) + 20'(tot) + 20'(fo);
    assign sum_f1  = 17'(sum_raw[15:0]) + 17'(sum_raw[19:16]);
    assign sum_f2  = sum_f1[15:0] + 16'(sum_f1[16]);
    assign hdr_sum = ~sum_f2;

    assign out_valid_next = cmd.step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg   <= '0;
            next_ident_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                local_ip_reg <= cfg_wr_data;
            if (cmd.load)
                next_ident_reg <= next_ident_reg + 16'd1;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg      <= in_len;
            start_reg    <= '0;
            k_reg        <= '0;
            ident_reg    <= next_ident_reg;
            base_sum_reg <= base_sum;
        end
        else if (cmd.step)
        begin
            rem_reg   <= rem_reg - FRAG_W;
            start_reg <= start_reg + FRAG_W;
            k_reg     <= k_reg + FRAG_CNT_W'(1);
        end
        if (cmd.step)
        begin
            out_data_reg <= {4'd0, slen, start_reg, hdr_sum, fo, ident_reg, tot};
            out_last_reg <= frag_last;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;
    assign m_tlast        = out_last_reg;
    assign stat.out_valid = out_valid_reg;
    assign stat.frag_last = frag_last;

endmodule

// ===== rtl/core/ipv4_tx_fragment_header_gen.sv =====
// Top level of the IPv4 transmit fragment header generator.
// The first header is built from the registered request, then held in the output register.
// Throughput: one fragment header per cycle while the output register is free or draining,
//   ceil(payload_len / FRAG_PAYLOAD) beats, at least one and at most 45 per request.
// Next request is taken the cycle after the last fragment is loaded for output.
// Reset (rst_n, async, active low): local_ip and the identifier counter clear to 0.
module ipv4_tx_fragment_header_gen
    import iftfg_pkg::*;
#(
    parameter int FRAG_PAYLOAD = 1480   // fragment payload bytes, 8..1480
)
(
    input  logic             clk,
    input  logic             rst_n,
    // source address register
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    // request stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // payload_len[15:0], dest_addr[47:16], proto_num[55:48]
    // fragment header stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // total_length[10:0], ident[26:11],
                                        // flags_offset[40:27], hdr_sum[56:41],
                                        // slice_start[72:57], slice_len[83:73], zero pad
    output logic             m_tlast    // last fragment of the request
);

    iftfg_cmd_t  cmd;
    iftfg_stat_t stat;

    // Controller: idle until a request beat, then steps one fragment per
    // cycle whenever the output register is free or being drained.
    iftfg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: remaining-length walk, per-fragment checksum with the
    // constant header words summed once at request intake.
    iftfg_dp #(
        .FRAG_PAYLOAD (FRAG_PAYLOAD)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== verif/tb_ipv4_tx_fragment_header_gen.sv =====
// Testbench for ipv4_tx_fragment_header_gen: fragment header prediction and stream checking.
`timescale 1ns / 100ps

module tb_ipv4_tx_fragment_header_gen;
    import iftfg_pkg::*;

    // Fragment payload size the DUT is built with; the predictor uses the same value.
    localparam int FRAG_BYTES = 1480;
    // Generous wall for the whole run, in nanoseconds.
    localparam longint RUN_LIMIT_NS = 64'd20_000_000;
    localparam int RAND_PHASES = 5;
    localparam int ITEMS_PER_PHASE = 54;

    // One fragment header as it leaves the block.
    typedef struct packed {
        logic [10:0] total_length;
        logic [15:0] ident;
        logic [13:0] flags_offset;
        logic [15:0] hdr_sum;
        logic [15:0] slice_start;
        logic [10:0] slice_len;
        logic        last;
    } frag_hdr_t;

    // Predicts the fragment headers of each request and checks the output
    // stream against them in order.
    class frag_scoreboard;
        frag_hdr_t   expected_q[$];
        logic [31:0] source_ip;
        logic [15:0] ident_ctr;
        int          errors;

        function new();
            source_ip = '0;
            ident_ctr = '0;
            errors    = 0;
        endfunction

        function void set_source(logic [31:0] ip);
            source_ip = ip;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        // One's-complement sum over the ten header words, checksum word as zero.
        function logic [15:0] hdr_checksum(logic [10:0] tot, logic [15:0] id,
                                           logic [13:0] fo, logic [7:0] proto,
                                           logic [31:0] dst);
            logic [31:0] acc;
            acc = VER_IHL_TOS + tot + id + fo + {TTL_VALUE, proto}
                + source_ip[31:16] + source_ip[15:0] + dst[31:16] + dst[15:0];
            acc = acc[15:0] + acc[31:16];
            acc = acc[15:0] + acc[31:16];
            return ~acc[15:0];
        endfunction

        // Accepted request beat: take an identifier and queue every fragment.
        function void note_request(logic [15:0] len, logic [31:0] dst, logic [7:0] proto);
            int unsigned count;
            int unsigned start;
            int unsigned slen;
            int unsigned fo;
            logic [15:0] id;
            frag_hdr_t   f;
            id = ident_ctr;
            ident_ctr = ident_ctr + 16'd1;
            count = (len <= FRAG_BYTES) ? 1 : (len + FRAG_BYTES - 1) / FRAG_BYTES;
            if (count > MAX_FRAGS)
                count = MAX_FRAGS;
            for (int unsigned k = 0; k < count; k++)
            begin
                start = k * FRAG_BYTES;
                if (k + 1 != count)
                    slen = FRAG_BYTES;
                else if (len >= start && len - start <= FRAG_BYTES)
                    slen = len - start;
                else
                    slen = FRAG_BYTES;   // truncated walk: last beat still full
                fo = (start / 8) & 32'h1FFF;
                if (k + 1 != count)
                    fo = fo | 32'h2000;  // MF
                f.total_length = 11'(slen + HDR_BYTES);
                f.ident        = id;
                f.flags_offset = 14'(fo);
                f.hdr_sum      = hdr_checksum(f.total_length, id, f.flags_offset, proto, dst);
                f.slice_start  = 16'(start);
                f.slice_len    = 11'(slen);
                f.last         = (k + 1 == count);
                expected_q.push_back(f);
            end
        endfunction

        function void compare_field(string name, int unsigned exp_val,
                                    int unsigned got_val, logic [15:0] id);
            if (exp_val != got_val)
                report($sformatf("%s expected %0h got %0h (ident %0h)",
                                 name, exp_val, got_val, id));
        endfunction

        // Accepted output beat: compare with the oldest prediction.
        function void check_fragment(frag_hdr_t got);
            frag_hdr_t exp_f;
            if (expected_q.size() == 0)
            begin
                report($sformatf("fragment beat with nothing pending (ident %0h)", got.ident));
                return;
            end
            exp_f = expected_q.pop_front();
            compare_field("total_length", exp_f.total_length, got.total_length, exp_f.ident);
            compare_field("ident",        exp_f.ident,        got.ident,        exp_f.ident);
            compare_field("flags_offset", exp_f.flags_offset, got.flags_offset, exp_f.ident);
            compare_field("hdr_sum",      exp_f.hdr_sum,      got.hdr_sum,      exp_f.ident);
            compare_field("slice_start",  exp_f.slice_start,  got.slice_start,  exp_f.ident);
            compare_field("slice_len",    exp_f.slice_len,    got.slice_len,    exp_f.ident);
            compare_field("last",         exp_f.last,         got.last,         exp_f.ident);
        endfunction
    endclass

    // DUT connections; every input has a known value from time zero.
    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [31:0]      cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata     = '0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    // Both sides skip their random gaps while this is set.
    logic             no_idle     = 1'b0;

    frag_scoreboard   sb = new();

    ipv4_tx_fragment_header_gen #(
        .FRAG_PAYLOAD (FRAG_BYTES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Single reset at the start.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the stream hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Source address write; only called with the block idle.
    task automatic write_source_ip(input logic [31:0] ip);
        cfg_wr_data <= ip;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_source(ip);
    endtask

    // Stop sending and wait until every predicted fragment has come out,
    // then wait out an extra slack period.
    task automatic drain_fragments();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One request beat with a random lead-in gap. tvalid is left high so a
    // back-to-back beat never toggles it within one step.
    task automatic send_request(input logic [15:0] len, input logic [31:0] dst,
                                input logic [7:0] proto);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {proto, dst, len};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_request(len, dst, proto);
    endtask

    // Payload length mix: mostly one to four fragments, fragment boundaries,
    // and now and then a long walk up to the 45-fragment maximum.
    function automatic logic [15:0] pick_payload_len();
        int unsigned k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, FRAG_BYTES));
            4, 5, 6:    return 16'($urandom_range(FRAG_BYTES + 1, 4 * FRAG_BYTES));
            7:
            begin
                k = $urandom_range(1, 44);
                return 16'(k * FRAG_BYTES + $urandom_range(0, 2) - 1);
            end
            8:          return 16'($urandom_range(0, 65515));
            default:    return 16'($urandom_range(65000, 65515));
        endcase
    endfunction

    // Output side: random stalls on tready, check each accepted beat.
    initial
    begin
        frag_hdr_t got;
        int        stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            got.total_length = m_tdata[10:0];
            got.ident        = m_tdata[26:11];
            got.flags_offset = m_tdata[40:27];
            got.hdr_sum      = m_tdata[56:41];
            got.slice_start  = m_tdata[72:57];
            got.slice_len    = m_tdata[83:73];
            got.last         = m_tlast;
            sb.check_fragment(got);
        end
    end

    // Stimulus: directed corners under the reset source address, then
    // random phases, each under its own source address.
    initial
    begin
        logic [31:0] ip;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed: empty payload, field extremes, fragment boundaries,
        // longest walk, alternating bit patterns.
        send_request(16'd0,     32'h0000_0000, 8'h00);
        send_request(16'd0,     32'hFFFF_FFFF, 8'hFF);
        send_request(16'd1,     32'h0A00_0001, 8'h11);
        send_request(16'd8,     32'h0A00_0002, 8'h06);
        send_request(16'd1479,  32'hC0A8_0001, 8'h01);
        send_request(16'd1480,  32'hC0A8_0002, 8'h11);
        send_request(16'd1481,  32'hC0A8_0003, 8'h06);
        send_request(16'd2959,  32'h7F00_0001, 8'h11);
        send_request(16'd2960,  32'h7F00_0001, 8'h11);
        send_request(16'd2961,  32'h7F00_0001, 8'h11);
        send_request(16'd4440,  32'hE000_0001, 8'h02);
        send_request(16'd65119, 32'h0102_0304, 8'h11);
        send_request(16'd65120, 32'h0102_0304, 8'h11);
        send_request(16'd65121, 32'h0102_0304, 8'h11);
        send_request(16'd65515, 32'hFFFF_FFFF, 8'hFF);
        send_request(16'hAAAA,  32'hAAAA_AAAA, 8'hAA);
        send_request(16'h5555,  32'h5555_5555, 8'h55);
        drain_fragments();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       ip = 32'hFFFF_FFFF;
                1:       ip = 32'h0000_0000;
                2:       ip = 32'hC0A8_0101;
                default: ip = $urandom;
            endcase
            write_source_ip(ip);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Opening stretch of each phase runs with no gaps on either side.
                no_idle <= (i < 12);
                send_request(pick_payload_len(), $urandom, 8'($urandom_range(0, 255)));
            end
            // Sender holds off until every fragment is out before reconfiguring.
            drain_fragments();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/iftfg_pkg.sv
rtl/core/iftfg_ctrl.sv
rtl/core/iftfg_dp.sv
rtl/core/ipv4_tx_fragment_header_gen.sv
verif/tb_ipv4_tx_fragment_header_gen.sv
